[src/tcrs_pkg.sv]
// Shared types, codes and defaults of the three-class ratio scheduler.
`default_nettype none
package tcrs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_WIDTH_DEF   = 16;

    localparam logic [7:0] RATIO_RST   = 8'd4;
    localparam logic [7:0] WORKERS_RST = 8'd1;

    localparam logic REG_RATIO   = 1'b0;
    localparam logic REG_WORKERS = 1'b1;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] CLS_HIGH = 2'd0;
    localparam logic [1:0] CLS_MED  = 2'd1;
    localparam logic [1:0] CLS_LOW  = 2'd2;
    localparam logic [1:0] CLS_NONE = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage
`default_nettype wire

[src/tcrs_ctrl.sv]
// Sequencer: accepts one transaction, runs it through the datapath, hands off the result.
`default_nettype none
module tcrs_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire tcrs_pkg::sts_t sts,
    output tcrs_pkg::cmd_t     cmd
);

    tcrs_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcrs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tcrs_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = tcrs_pkg::ST_EXEC;
            end
            tcrs_pkg::ST_EXEC: begin
                state_next = tcrs_pkg::ST_EMIT;
            end
            tcrs_pkg::ST_EMIT: begin
                if (sts.out_free) state_next = tcrs_pkg::ST_IDLE;
            end
            default: begin
                state_next = tcrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.capture  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            tcrs_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            tcrs_pkg::ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            tcrs_pkg::ST_EMIT: begin
                cmd.load_out = sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

[src/tcrs_datapath.sv]
// Queue store, pointers, grant decision, config registers and output register.
`default_nettype none
module tcrs_datapath #(
    parameter int QUEUE_DEPTH = tcrs_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = tcrs_pkg::TAG_WIDTH_DEF,
    localparam int DW = ((TAG_WIDTH + 3 + 7) / 8) * 8,
    localparam int OW = ((TAG_WIDTH + 5 + 7) / 8) * 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [DW-1:0]  s_tdata,
    input  wire logic [1:0]     s_tuser,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [OW-1:0]       m_tdata,
    input  wire logic           cfg_we,
    input  wire logic           cfg_index,
    input  wire logic [7:0]     cfg_data,
    input  wire tcrs_pkg::cmd_t cmd,
    output tcrs_pkg::sts_t      sts
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(3 * QUEUE_DEPTH);
    localparam int MW = (CW > 8) ? CW : 8;

    logic [TAG_WIDTH-1:0] mem [3*QUEUE_DEPTH];

    logic [1:0]           op_reg;
    logic [1:0]           cls_reg;
    logic [TAG_WIDTH-1:0] tag_reg;
    logic                 fin_reg;
    logic [7:0]           ratio_reg;
    logic [7:0]           workers_reg;
    logic [PW-1:0]        head_reg  [3];
    logic [PW-1:0]        head_next [3];
    logic [CW-1:0]        count_reg  [3];
    logic [CW-1:0]        count_next [3];
    logic [7:0]           msc_reg, msc_next;

    logic                 res_valid_reg, res_valid_next;
    logic [1:0]           res_cls_reg, res_cls_next;
    logic                 res_wake_reg, res_wake_next;
    logic                 res_drop_reg, res_drop_next;
    logic                 res_mem_reg, res_mem_next;
    logic [TAG_WIDTH-1:0] res_tag_reg, res_tag_next;
    logic [TAG_WIDTH-1:0] rd_data_reg;
    logic                 m_valid_reg;
    logic [OW-1:0]        m_data_reg;

    logic [1:0]           cls_in;
    logic [1:0]           pick;
    logic [1:0]           pick_idx;
    logic                 mem_we;
    logic [AW-1:0]        waddr;
    logic [AW-1:0]        raddr;
    logic [PW:0]          wsum;
    logic [PW-1:0]        wpos;
    logic [PW:0]          hinc;
    logic [TAG_WIDTH-1:0] job;

    function automatic logic [AW-1:0] class_base(input logic [1:0] c);
        logic [AW-1:0] b;
        case (c)
            tcrs_pkg::CLS_MED: b = AW'(QUEUE_DEPTH);
            tcrs_pkg::CLS_LOW: b = AW'(2 * QUEUE_DEPTH);
            default:           b = '0;
        endcase
        return b;
    endfunction

    assign cls_in = (s_tdata[1:0] == tcrs_pkg::CLS_NONE) ? tcrs_pkg::CLS_LOW : s_tdata[1:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg  <= s_tuser;
            cls_reg <= cls_in;
            tag_reg <= s_tdata[TAG_WIDTH+1:2];
            fin_reg <= s_tdata[TAG_WIDTH+2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg   <= tcrs_pkg::RATIO_RST;
            workers_reg <= tcrs_pkg::WORKERS_RST;
        end else if (cfg_we) begin
            if (cfg_index == tcrs_pkg::REG_RATIO) begin
                ratio_reg <= cfg_data;
            end else begin
                workers_reg <= cfg_data;
            end
        end
    end

    // grant: high first, low once the medium run reaches the ratio, then medium, then low
    always_comb begin
        if (count_reg[0] != '0) begin
            pick = tcrs_pkg::CLS_HIGH;
        end else if (msc_reg >= ratio_reg && count_reg[2] != '0) begin
            pick = tcrs_pkg::CLS_LOW;
        end else if (count_reg[1] != '0) begin
            pick = tcrs_pkg::CLS_MED;
        end else if (count_reg[2] != '0) begin
            pick = tcrs_pkg::CLS_LOW;
        end else begin
            pick = tcrs_pkg::CLS_NONE;
        end
    end

    assign pick_idx = (pick == tcrs_pkg::CLS_NONE) ? tcrs_pkg::CLS_HIGH : pick;
    assign raddr    = class_base(pick_idx) + AW'(head_reg[pick_idx]);

    assign wsum  = {1'b0, head_reg[cls_reg]} + (PW+1)'(count_reg[cls_reg]);
    assign wpos  = (wsum >= (PW+1)'(QUEUE_DEPTH)) ? PW'(wsum - (PW+1)'(QUEUE_DEPTH))
                                                   : wsum[PW-1:0];
    assign waddr = class_base(cls_reg) + AW'(wpos);
    assign hinc  = {1'b0, head_reg[pick_idx]} + (PW+1)'(1);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            head_next[i]  = head_reg[i];
            count_next[i] = count_reg[i];
        end
        msc_next       = msc_reg;
        mem_we         = 1'b0;
        res_valid_next = 1'b0;
        res_cls_next   = tcrs_pkg::CLS_HIGH;
        res_wake_next  = 1'b0;
        res_drop_next  = 1'b0;
        res_mem_next   = 1'b0;
        res_tag_next   = '0;
        case (op_reg)
            tcrs_pkg::OP_PUSH: begin
                if (fin_reg) begin
                    res_drop_next = 1'b1;
                end else if (workers_reg == '0) begin
                    res_valid_next = 1'b1;
                    res_tag_next   = tag_reg;
                    res_cls_next   = cls_reg;
                end else if (count_reg[cls_reg] == CW'(QUEUE_DEPTH)) begin
                    res_drop_next = 1'b1;
                end else begin
                    mem_we                = 1'b1;
                    count_next[cls_reg]   = count_reg[cls_reg] + CW'(1);
                    res_wake_next         = MW'(count_reg[cls_reg]) <= MW'(workers_reg);
                end
            end
            tcrs_pkg::OP_POP: begin
                if (pick != tcrs_pkg::CLS_NONE) begin
                    res_valid_next       = 1'b1;
                    res_mem_next         = 1'b1;
                    res_cls_next         = pick;
                    count_next[pick_idx] = count_reg[pick_idx] - CW'(1);
                    head_next[pick_idx]  = (hinc == (PW+1)'(QUEUE_DEPTH)) ? '0 : hinc[PW-1:0];
                    if (pick == tcrs_pkg::CLS_LOW && msc_reg >= ratio_reg) begin
                        msc_next = '0;
                    end else if (pick == tcrs_pkg::CLS_MED && msc_reg != 8'hFF) begin
                        msc_next = msc_reg + 8'd1;
                    end
                end
            end
            tcrs_pkg::OP_CLEAR: begin
                for (int i = 0; i < 3; i++) begin
                    head_next[i]  = '0;
                    count_next[i] = '0;
                end
            end
            default: begin
                res_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
            msc_reg <= '0;
        end else if (cmd.exec) begin
            for (int i = 0; i < 3; i++) begin
                head_reg[i]  <= head_next[i];
                count_reg[i] <= count_next[i];
            end
            msc_reg <= msc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_valid_reg <= res_valid_next;
            res_cls_reg   <= res_cls_next;
            res_wake_reg  <= res_wake_next;
            res_drop_reg  <= res_drop_next;
            res_mem_reg   <= res_mem_next;
            res_tag_reg   <= res_tag_next;
        end
    end

    // read data held until the result is loaded
    always_ff @(posedge aclk) begin
        if (cmd.exec && mem_we) begin
            mem[waddr] <= tag_reg;
        end
        if (cmd.exec) begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign job = res_mem_reg ? rd_data_reg : res_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg <= OW'({res_drop_reg, res_wake_reg, res_cls_reg, job, res_valid_reg});
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign m_tdata      = m_data_reg;
    assign sts.out_free = !m_valid_reg || m_tready;

endmodule
`default_nettype wire

[src/three_class_ratio_scheduler.sv]
// Top level of the three-class ratio scheduler.
// Takes push, pop and clear transactions on the s_ side and returns exactly one
// result transaction per input on the m_ side. One transaction is in flight at a
// time: the accepting edge is followed by the queue update with the registered
// tag-store read, then by the output load once the output is free, which raises
// m_tvalid; s_tready is high again in that same cycle. No new transaction is taken
// until the last result is loaded; m_tready low holds the output register. The three
// tag queues share one single-port-write, registered-read memory of 3*QUEUE_DEPTH
// entries. No clearing pass after reset. Configuration writes land on the next clock
// edge; the user must make them only while the block is idle, which it does not enforce.
`default_nettype none
module three_class_ratio_scheduler #(
    parameter int QUEUE_DEPTH = tcrs_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = tcrs_pkg::TAG_WIDTH_DEF,
    localparam int DW = ((TAG_WIDTH + 3 + 7) / 8) * 8,
    localparam int OW = ((TAG_WIDTH + 5 + 7) / 8) * 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // priority_class, job_tag, already_finished
    input  wire logic [DW-1:0] s_tdata,
    // op
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // tag_valid, job_out, served_class, wake, dropped
    output logic [OW-1:0]      m_tdata,
    input  wire logic          cfg_we,
    input  wire logic          cfg_index,
    input  wire logic [7:0]    cfg_data
);

    tcrs_pkg::cmd_t cmd;
    tcrs_pkg::sts_t sts;

    tcrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tcrs_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_WIDTH   (TAG_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted while one in flight");

    a_valid_not_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[TAG_WIDTH+4]))
        else $error("result both dispatched and dropped");

    a_wake_not_dropped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[TAG_WIDTH+3] && m_tdata[TAG_WIDTH+4]))
        else $error("wake raised on a dropped push");

    a_class_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[TAG_WIDTH+2:TAG_WIDTH+1] != tcrs_pkg::CLS_NONE)
        else $error("served class out of range");

endmodule
`default_nettype wire
